// ===== design/dbw_pkg.sv =====
// dbw_pkg: widths, reset values and register indexes for the depth back-projection block
// no dependencies; used by depth_backproject_to_world by scoped names
package dbw_pkg;

    localparam int DEPTH_W   = 32;
    localparam int PIX_W     = 12;
    localparam int COEF_W    = 21;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int OFS_W     = 32;
    localparam int ROWS_W    = 13;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int AXES      = 3;
    localparam int FRAC_W    = 16;

    // internal widths
    localparam int V_W    = ROWS_W + 2;           // flipped row, signed
    localparam int PCOL_W = COEF_W + PIX_W + 1;   // coef * column
    localparam int PV_W   = COEF_W + V_W;         // coef * flipped row
    localparam int ACC_W  = PV_W;                 // sum of both products plus constant
    localparam int DH_W   = DEPTH_W - FRAC_W + 1; // depth half, zero extended
    localparam int PROD_W = ACC_W + DH_W;
    localparam int P_W    = PROD_W + 1;
    localparam int SUM_W  = P_W + 1;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0  = 3'd0,
        CFG_ROW1  = 3'd1,
        CFG_ROW2  = 3'd2,
        CFG_OFS_X = 3'd3,
        CFG_OFS_Y = 3'd4,
        CFG_OFS_Z = 3'd5,
        CFG_ROWS  = 3'd6
    } cfg_index_t;

endpackage

// ===== design/depth_backproject_to_world.sv =====
// depth_backproject_to_world: six-stage pipeline, pixel (depth, col, row) to world point
// depends on dbw_pkg for widths, reset values and register indexes
// path: an accepted input word passes through the s1 to s5 registers, then the output register that drives out_valid
// throughput: one word per cycle; all stages advance together when the output register frees
// reset: clears the pipeline valid bits (not point_valid) and loads registers with zero matrix, zero offset, 480 rows
module depth_backproject_to_world #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [dbw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbw_pkg::ROW_W-1:0]         cfg_data,
    // input words
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dbw_pkg::DEPTH_W-1:0]       depth_sample,
    input  logic [dbw_pkg::PIX_W-1:0]         pixel_col,
    input  logic [dbw_pkg::PIX_W-1:0]         pixel_row,
    // output words
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [dbw_pkg::OUT_W-1:0]  world_x,
    output logic signed [dbw_pkg::OUT_W-1:0]  world_y,
    output logic signed [dbw_pkg::OUT_W-1:0]  world_z,
    output logic                              point_valid
);

    localparam int AX = dbw_pkg::AXES;
    localparam int CW = dbw_pkg::COEF_W;
    localparam int RW = dbw_pkg::ROWS_W;
    // clamp constant, wide enough for any legal MAX_DIM
    localparam logic [RW+3:0] MAX_DIM_W = (RW+4)'(MAX_DIM);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [dbw_pkg::ROW_W-1:0]          matrix_reg [AX];
    logic signed [dbw_pkg::OFS_W-1:0]   offset_reg [AX];
    logic [RW-1:0]                      image_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AX; i++)
            begin
                matrix_reg[i] <= '0;
                offset_reg[i] <= '0;
            end
            image_rows_reg <= dbw_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dbw_pkg::CFG_ROW0:  matrix_reg[0]  <= cfg_data;
                dbw_pkg::CFG_ROW1:  matrix_reg[1]  <= cfg_data;
                dbw_pkg::CFG_ROW2:  matrix_reg[2]  <= cfg_data;
                dbw_pkg::CFG_OFS_X: offset_reg[0]  <= cfg_data[dbw_pkg::OFS_W-1:0];
                dbw_pkg::CFG_OFS_Y: offset_reg[1]  <= cfg_data[dbw_pkg::OFS_W-1:0];
                dbw_pkg::CFG_OFS_Z: offset_reg[2]  <= cfg_data[dbw_pkg::OFS_W-1:0];
                dbw_pkg::CFG_ROWS:  image_rows_reg <= cfg_data[RW-1:0];
                default: ; // index beyond the register list is dropped
            endcase
        end
    end

    // image height clamped to MAX_DIM, used for the vertical flip
    logic [RW-1:0] rows_clamped;
    always_comb
    begin
        if ({4'b0, image_rows_reg} > MAX_DIM_W)
            rows_clamped = MAX_DIM_W[RW-1:0];
        else
            rows_clamped = image_rows_reg;
    end

    // ---------------------------------------------------------------
    // pipeline control: one global advance, output register acts as the stall point
    // ---------------------------------------------------------------
    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: capture input word
    // ---------------------------------------------------------------
    logic [dbw_pkg::DEPTH_W-1:0] s1_depth_reg;
    logic [dbw_pkg::PIX_W-1:0]   s1_col_reg;
    logic [dbw_pkg::PIX_W-1:0]   s1_row_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_depth_reg <= depth_sample;
            s1_col_reg   <= pixel_col;
            s1_row_reg   <= pixel_row;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: flip row, coefficient products for column and flipped row
    // ---------------------------------------------------------------
    logic signed [dbw_pkg::V_W-1:0]    v_flip;
    logic signed [dbw_pkg::PIX_W:0]    col_s;
    logic signed [dbw_pkg::PCOL_W-1:0] s2_pcol_next [AX];
    logic signed [dbw_pkg::PV_W-1:0]   s2_pv_next   [AX];
    logic signed [dbw_pkg::PCOL_W-1:0] s2_pcol_reg  [AX];
    logic signed [dbw_pkg::PV_W-1:0]   s2_pv_reg    [AX];
    logic [dbw_pkg::DEPTH_W-1:0]       s2_depth_reg;

    always_comb
    begin
        v_flip = $signed({2'b00, rows_clamped}) - $signed({3'b000, s1_row_reg});
        col_s  = $signed({1'b0, s1_col_reg});
        for (int i = 0; i < AX; i++)
        begin
            s2_pcol_next[i] = $signed(matrix_reg[i][0 +: CW]) * col_s;
            s2_pv_next[i]   = $signed(matrix_reg[i][CW +: CW]) * v_flip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pcol_reg  <= s2_pcol_next;
            s2_pv_reg    <= s2_pv_next;
            s2_depth_reg <= s1_depth_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: acc = m0*col + m1*v + m2, exact in Q.16
    // ---------------------------------------------------------------
    logic signed [dbw_pkg::ACC_W-1:0] s3_acc_next [AX];
    logic signed [dbw_pkg::ACC_W-1:0] s3_acc_reg  [AX];
    logic [dbw_pkg::DEPTH_W-1:0]      s3_depth_reg;

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            s3_acc_next[i] = dbw_pkg::ACC_W'(s2_pcol_reg[i])
                           + s2_pv_reg[i]
                           + dbw_pkg::ACC_W'($signed(matrix_reg[i][2*CW +: CW]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_acc_reg   <= s3_acc_next;
            s3_depth_reg <= s2_depth_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: scale by depth, split into integer and fraction halves
    // ---------------------------------------------------------------
    logic signed [dbw_pkg::DH_W-1:0]   dh_s;
    logic signed [dbw_pkg::DH_W-1:0]   dl_s;
    logic signed [dbw_pkg::PROD_W-1:0] s4_ph_next [AX];
    logic signed [dbw_pkg::PROD_W-1:0] s4_pl_next [AX];
    logic signed [dbw_pkg::PROD_W-1:0] s4_ph_reg  [AX];
    logic signed [dbw_pkg::PROD_W-1:0] s4_pl_reg  [AX];
    logic                              s4_nz_reg;

    always_comb
    begin
        dh_s = $signed({1'b0, s3_depth_reg[dbw_pkg::DEPTH_W-1:dbw_pkg::FRAC_W]});
        dl_s = $signed({1'b0, s3_depth_reg[dbw_pkg::FRAC_W-1:0]});
        for (int i = 0; i < AX; i++)
        begin
            s4_ph_next[i] = s3_acc_reg[i] * dh_s;
            s4_pl_next[i] = s3_acc_reg[i] * dl_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ph_reg <= s4_ph_next;
            s4_pl_reg <= s4_pl_next;
            s4_nz_reg <= |s3_depth_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: p = acc*dh + floor((acc*dl + half) / 2^16), half rounds up
    // ---------------------------------------------------------------
    logic signed [dbw_pkg::PROD_W-1:0] pl_round [AX];
    logic signed [dbw_pkg::P_W-1:0]    s5_p_next [AX];
    logic signed [dbw_pkg::P_W-1:0]    s5_p_reg  [AX];
    logic                              s5_nz_reg;

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            pl_round[i]  = s4_pl_reg[i]
                         + dbw_pkg::PROD_W'(1 << (dbw_pkg::FRAC_W - 1));
            s5_p_next[i] = dbw_pkg::P_W'(s4_ph_reg[i])
                         + dbw_pkg::P_W'($signed(
                               pl_round[i][dbw_pkg::PROD_W-1:dbw_pkg::FRAC_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_p_reg  <= s5_p_next;
            s5_nz_reg <= s4_nz_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: add offset, saturate to Q24.16, zero point for missing depth
    // ---------------------------------------------------------------
    localparam int OW = dbw_pkg::OUT_W;
    localparam int SW = dbw_pkg::SUM_W;

    logic signed [SW-1:0] sum [AX];
    logic signed [OW-1:0] out_next [AX];
    logic signed [OW-1:0] out_reg  [AX];
    logic                 point_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            sum[i] = SW'(s5_p_reg[i]) + SW'(offset_reg[i]);
            if (!s5_nz_reg)
                out_next[i] = '0;
            else if (sum[i][SW-1] && !(&sum[i][SW-2:OW-1]))
                out_next[i] = {1'b1, {(OW-1){1'b0}}};  // negative limit
            else if (!sum[i][SW-1] && (|sum[i][SW-2:OW-1]))
                out_next[i] = {1'b0, {(OW-1){1'b1}}};  // positive limit
            else
                out_next[i] = sum[i][OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg         <= out_next;
            point_valid_reg <= s5_nz_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign world_x     = out_reg[0];
    assign world_y     = out_reg[1];
    assign world_z     = out_reg[2];
    assign point_valid = point_valid_reg;

endmodule
